// ===== rtl/rxla_pkg.sv =====
// ----------------------------------------------------------------------------
// rxla_pkg
// Types and constants shared by the receive ring / line assembler files.
// ----------------------------------------------------------------------------
package rxla_pkg;

	// Command codes of a request beat
	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_LINE  = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	// Status codes of a response beat
	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_DROPPED = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_NO_LINE = 3'd3,
		ST_CHAR    = 3'd4
	} status_t;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] rx_data;
		logic [6:0] out_limit;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       last;
	} rsp_t;

endpackage

// ===== rtl/rxla_stream_if.sv =====
// ----------------------------------------------------------------------------
// rxla_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface rxla_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rxla_ram.sv =====
// ----------------------------------------------------------------------------
// rxla_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rxla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, and read data that holds until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/rx_ring_fifo_line_assembler.sv =====
// ----------------------------------------------------------------------------
// rx_ring_fifo_line_assembler
// Receive byte ring with a line assembler on top of two small RAMs.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents                      handshake
//  req      in   opcode, rx_data, out_limit         valid/ready
//  rsp      out  out_byte, status, last             valid/ready
//
//  Push, clear and an empty pop go through S_RESULT; a pop reads the ring RAM,
//  then loads its byte in S_POP_DATA. Read line drains the ring byte by byte
//  (read, then decode) and emits each character (line RAM read, then output
//  load); a line cut to nothing, or a ring drained with no line, ends in S_RESULT.
//  One command is in work at a time; req.ready is high only when it is done.
//  Reset clears pointers and line length at once; there is no clearing pass.
//  A stalled rsp holds the engine at its next output load; a req can still
//  be taken while the last response beat waits in the output register.
// ----------------------------------------------------------------------------
module rx_ring_fifo_line_assembler #(
	parameter int RING_DEPTH    = 256,
	parameter int LINE_CAPACITY = 64
) (
	input logic clk,
	input logic arst_n,
	rxla_stream_if.sink   req,
	rxla_stream_if.source rsp
);
	import rxla_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);
	localparam int LW = $clog2(LINE_CAPACITY);
	localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
	localparam logic [LW-1:0] LEN_MAX  = LW'(LINE_CAPACITY - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESULT,
		S_POP_DATA,
		S_DRAIN,
		S_DRAIN_DATA,
		S_LINE_RD,
		S_LINE_OUT
	} state_t;

	state_t        state_q;
	logic [PW-1:0] wp_q, rp_q;
	logic [LW-1:0] len_q, n_q, idx_q;
	logic [6:0]    lim_q;
	rsp_t          res_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic          acc, slot_free, ring_full, ring_empty, eol, out_load;
	logic [PW-1:0] wp_next, rp_next;
	logic          ring_we, ring_re, line_we, line_re;
	logic [7:0]    ring_rdata, line_rdata;
	logic [6:0]    len_ext, room, n_full;
	logic [LW-1:0] n_calc;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// Handshake and ring status
	assign req.ready  = (state_q == S_IDLE);
	assign acc        = req.valid && req.ready;
	assign rsp.valid  = out_valid_q;
	assign rsp.data   = out_q;
	assign slot_free  = !out_valid_q || rsp.ready;
	assign out_load   = slot_free && ((state_q == S_RESULT) ||
		(state_q == S_POP_DATA) || (state_q == S_LINE_OUT));
	assign wp_next    = ring_next(wp_q);
	assign rp_next    = ring_next(rp_q);
	assign ring_full  = (wp_next == rp_q);
	assign ring_empty = (rp_q == wp_q);
	assign eol        = (ring_rdata == CH_LF) || (ring_rdata == CH_CR);

	// Emitted length: line length cut to out_limit-1
	always_comb begin
		len_ext = 7'(len_q);
		room    = (lim_q == 7'd0) ? 7'd0 : lim_q - 7'd1;
		n_full  = (len_ext < room) ? len_ext : room;
		n_calc  = n_full[LW-1:0];
	end

	// Memory port controls
	assign ring_we = acc && (req.data.opcode == OP_PUSH) && !ring_full;
	assign ring_re = (acc && (req.data.opcode == OP_POP) && !ring_empty) ||
		((state_q == S_DRAIN) && !ring_empty);
	assign line_we = (state_q == S_DRAIN_DATA) && !eol && (len_q < LEN_MAX);
	assign line_re = (state_q == S_LINE_RD);

	rxla_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wp_q),
		.wdata (req.data.rx_data),
		.re    (ring_re),
		.raddr (rp_q),
		.rdata (ring_rdata)
	);

	rxla_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (len_q),
		.wdata (ring_rdata),
		.re    (line_re),
		.raddr (idx_q),
		.rdata (line_rdata)
	);

	// Command sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			len_q       <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			lim_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output beat loads, or clears once taken
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (req.data.opcode)
							OP_PUSH: begin
								if (ring_full) begin
									res_q <= '{out_byte: 8'd0, status: ST_DROPPED, last: 1'b1};
								end else begin
									res_q <= '{out_byte: 8'd0, status: ST_DONE, last: 1'b1};
									wp_q  <= wp_next;
								end
								state_q <= S_RESULT;
							end
							OP_POP: begin
								if (ring_empty) begin
									res_q   <= '{out_byte: 8'd0, status: ST_EMPTY, last: 1'b1};
									state_q <= S_RESULT;
								end else begin
									rp_q    <= rp_next;
									state_q <= S_POP_DATA;
								end
							end
							OP_CLEAR: begin
								res_q   <= '{out_byte: 8'd0, status: ST_DONE, last: 1'b1};
								rp_q    <= wp_q;
								len_q   <= '0;
								state_q <= S_RESULT;
							end
							OP_LINE: begin
								lim_q   <= req.data.out_limit;
								state_q <= S_DRAIN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RESULT: begin
					if (slot_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				S_POP_DATA: begin
					if (slot_free) begin
						out_q   <= '{out_byte: ring_rdata, status: ST_DONE, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_DRAIN: begin
					if (ring_empty) begin
						res_q   <= '{out_byte: 8'd0, status: ST_NO_LINE, last: 1'b1};
						state_q <= S_RESULT;
					end else begin
						rp_q    <= rp_next;
						state_q <= S_DRAIN_DATA;
					end
				end
				S_DRAIN_DATA: begin
					if (eol) begin
						if (len_q == '0) begin
							// empty line: skip and keep draining
							state_q <= S_DRAIN;
						end else begin
							len_q <= '0;
							n_q   <= n_calc;
							idx_q <= '0;
							if (n_calc == '0) begin
								res_q   <= '{out_byte: 8'd0, status: ST_DONE, last: 1'b1};
								state_q <= S_RESULT;
							end else begin
								state_q <= S_LINE_RD;
							end
						end
					end else begin
						// overlong lines drop the excess characters
						if (len_q < LEN_MAX) begin
							len_q <= len_q + 1'b1;
						end
						state_q <= S_DRAIN;
					end
				end
				S_LINE_RD: begin
					state_q <= S_LINE_OUT;
				end
				S_LINE_OUT: begin
					if (slot_free) begin
						out_q   <= '{out_byte: line_rdata, status: ST_CHAR,
							last: (idx_q == n_q - 1'b1)};
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q == n_q - 1'b1) ? S_IDLE : S_LINE_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Ring RAM is never written and read in the same cycle
	a_ring_ports: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_we && ring_re))
		else $error("ring RAM written and read in one cycle");

	// Line length stays within the line store
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("line length beyond line store");

	// A waiting response beat is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready && state_q != S_IDLE && state_q != S_DRAIN &&
		state_q != S_DRAIN_DATA && state_q != S_LINE_RD) |=> $stable(out_q))
		else $error("response beat overwritten while stalled");

	// Clear leaves the ring empty
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.data.opcode == OP_CLEAR) |=> (rp_q == wp_q && len_q == '0))
		else $error("clear did not empty the ring");
endmodule
